// ===== rtl/assert_macros.svh =====
// Assertion helpers for the files that check their own logic (the top module).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while out of reset.
`define EPOM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define EPOM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/epom_pkg.sv =====
`default_nettype none
package epom_pkg;

    localparam int DEF_LIST_DEPTH = 32;
    localparam int DEF_PRICE_BITS = 20;

    localparam int QTY_W     = 16;
    localparam int CLIENT_W  = 10;
    localparam int ID_W      = 31;
    localparam int KIND_W    = 3;
    localparam int CODE_W    = 11;
    localparam int NUM_LISTS = 4;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_DETACH = 2'd2;

    localparam logic [KIND_W-1:0] RES_FILL      = 3'd0;
    localparam logic [KIND_W-1:0] RES_RESTED    = 3'd1;
    localparam logic [KIND_W-1:0] RES_FILLED    = 3'd2;
    localparam logic [KIND_W-1:0] RES_REJECTED  = 3'd3;
    localparam logic [KIND_W-1:0] RES_CANCELLED = 3'd4;
    localparam logic [KIND_W-1:0] RES_NOT_FOUND = 3'd5;
    localparam logic [KIND_W-1:0] RES_DETACHED  = 3'd6;

    localparam logic [CODE_W-1:0] DETACHED_CODE = 11'h7FF;

    // Control broadcast from the sequencer to one row of cells.
    typedef struct packed {
        logic                shift;
        logic                wr_en;
        logic                detach;
        logic [CLIENT_W-1:0] det_client;
    } list_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/epom_req_if.sv =====
`default_nettype none
interface epom_req_if #(
    parameter int PRICE_BITS = epom_pkg::DEF_PRICE_BITS
);
    import epom_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic                  instrument;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_W-1:0]      quantity;
    logic [CLIENT_W-1:0]   client_id;
    logic [ID_W-1:0]       order_id;

    modport source (
        output valid, req_type, instrument, side, price, quantity, client_id, order_id,
        input  ready
    );
    modport sink (
        input  valid, req_type, instrument, side, price, quantity, client_id, order_id,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/epom_res_if.sv =====
`default_nettype none
interface epom_res_if #(
    parameter int PRICE_BITS = epom_pkg::DEF_PRICE_BITS
);
    import epom_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        result_kind;
    logic [PRICE_BITS-1:0]    fill_price;
    logic [QTY_W-1:0]         fill_quantity;
    logic                     fill_instrument;
    logic signed [CODE_W-1:0] buy_client;
    logic signed [CODE_W-1:0] sell_client;
    logic                     last_result;

    modport source (
        output valid, result_kind, fill_price, fill_quantity, fill_instrument,
               buy_client, sell_client, last_result,
        input  ready
    );
    modport sink (
        input  valid, result_kind, fill_price, fill_quantity, fill_instrument,
               buy_client, sell_client, last_result,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/epom_cell.sv =====
`default_nettype none
module epom_cell #(
    parameter int PRICE_BITS = epom_pkg::DEF_PRICE_BITS,
    parameter int EW = PRICE_BITS + epom_pkg::QTY_W + epom_pkg::CLIENT_W + 1 + epom_pkg::ID_W
) (
    input  wire logic                clk,
    input  wire epom_pkg::list_ctrl_t ctrl,
    input  wire logic                wr_sel,
    input  wire logic [EW-1:0]       wr_entry,
    input  wire logic [EW-1:0]       nxt_entry,
    output logic [EW-1:0]            entry
);
    import epom_pkg::*;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [QTY_W-1:0]      qty;
        logic [CLIENT_W-1:0]   client;
        logic                  detached;
        logic [ID_W-1:0]       id;
    } entry_t;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (wr_sel)
        begin
            entry_next = entry_t'(wr_entry);
        end
        else if (ctrl.shift)
        begin
            entry_next = entry_t'(nxt_entry);
        end
        else if (ctrl.detach && (entry_reg.client == ctrl.det_client))
        begin
            entry_next.detached = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// ===== rtl/epom_list.sv =====
`default_nettype none
module epom_list #(
    parameter int LIST_DEPTH = epom_pkg::DEF_LIST_DEPTH,
    parameter int PRICE_BITS = epom_pkg::DEF_PRICE_BITS,
    parameter int IDX_W = $clog2(LIST_DEPTH),
    parameter int EW = PRICE_BITS + epom_pkg::QTY_W + epom_pkg::CLIENT_W + 1 + epom_pkg::ID_W
) (
    input  wire logic                 clk,
    input  wire epom_pkg::list_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]     wr_pos,
    input  wire logic [EW-1:0]        wr_entry,
    output logic [EW-1:0]             head
);
    import epom_pkg::*;

    logic [EW-1:0] cell_q [LIST_DEPTH];

    // Every shift moves the row one place towards the head; the entry that
    // leaves the head may be written back at the end of the live part.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [EW-1:0] nxt;
        logic          sel;

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign nxt = '0;
        end
        else
        begin : g_mid
            assign nxt = cell_q[i+1];
        end

        assign sel = ctrl.wr_en && (wr_pos == IDX_W'(i));

        epom_cell #(
            .PRICE_BITS (PRICE_BITS),
            .EW         (EW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .wr_sel    (sel),
            .wr_entry  (wr_entry),
            .nxt_entry (nxt),
            .entry     (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule
`default_nettype wire

// ===== rtl/exact_price_order_matcher_top.sv =====
// Exact-price order matcher for two instruments, four order lists.
// Requests arrive on req (valid/ready); results leave on res (valid/ready).
// One request is taken at a time: ready is high only while no request is
// being worked. Each request gives one or more results; the final one has
// last_result set, and fills never do.
// An add walks the opposite list entry by entry, then rests or answers;
// a fill that the receiver stalls halts the walk. A cancel walks the lists
// one after another until a list holds the order. A detach marks the
// client's entries in every list as detached, then answers. The walk
// rotates a row of cells one place per cycle while it is not halted.
// Results wait in one output register; while it is full and not taken the
// walk halts, so nothing is lost. Reset empties all lists at once (no
// clearing pass) and drops any pending result.
`default_nettype none
`include "assert_macros.svh"
module exact_price_order_matcher_top #(
    parameter int LIST_DEPTH = epom_pkg::DEF_LIST_DEPTH,
    parameter int PRICE_BITS = epom_pkg::DEF_PRICE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    epom_req_if.sink  req,
    epom_res_if.source res
);
    import epom_pkg::*;

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int EW    = PRICE_BITS + QTY_W + CLIENT_W + 1 + ID_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ADD_WALK = 3'd1;
    localparam logic [2:0] ST_ADD_REST = 3'd2;
    localparam logic [2:0] ST_CAN_WALK = 3'd3;
    localparam logic [2:0] ST_DETACH   = 3'd4;
    localparam logic [2:0] ST_FINAL    = 3'd5;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [QTY_W-1:0]      qty;
        logic [CLIENT_W-1:0]   client;
        logic                  detached;
        logic [ID_W-1:0]       id;
    } entry_t;

    logic [2:0]            state_reg, state_next;
    logic                  inst_reg, inst_next;
    logic                  side_reg, side_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_W-1:0]      qty_reg, qty_next;
    logic [CLIENT_W-1:0]   cli_reg, cli_next;
    logic [ID_W-1:0]       oid_reg, oid_next;
    logic [1:0]            lsel_reg, lsel_next;
    logic [CNT_W-1:0]      u_reg, u_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic                  found_reg, found_next;
    logic [KIND_W-1:0]     fin_kind_reg, fin_kind_next;
    logic [CNT_W-1:0]      cnt_reg [NUM_LISTS];
    logic [CNT_W-1:0]      cnt_next [NUM_LISTS];

    logic                     out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]        out_kind_reg, out_kind_next;
    logic [PRICE_BITS-1:0]    out_price_reg, out_price_next;
    logic [QTY_W-1:0]         out_qty_reg, out_qty_next;
    logic                     out_inst_reg, out_inst_next;
    logic [CODE_W-1:0]        out_buy_reg, out_buy_next;
    logic [CODE_W-1:0]        out_sell_reg, out_sell_next;
    logic                     out_last_reg, out_last_next;

    list_ctrl_t    ctrl [NUM_LISTS];
    logic [EW-1:0] heads [NUM_LISTS];
    logic [IDX_W-1:0] wr_pos;
    entry_t        wr_entry;

    logic [1:0]        opp_idx, own_idx, act_idx, in_opp_idx;
    entry_t            head;
    logic              out_free;
    logic              match;
    logic [QTY_W-1:0]  trade;
    logic [QTY_W-1:0]  rem;
    logic              hit;
    logic [CODE_W-1:0] self_code, other_code;
    logic [CNT_W-1:0]  wsum;

    assign opp_idx    = {inst_reg, ~side_reg};
    assign own_idx    = {inst_reg, side_reg};
    assign in_opp_idx = {req.instrument, ~req.side};
    assign act_idx    = (state_reg == ST_ADD_WALK) ? opp_idx : lsel_reg;
    assign head       = entry_t'(heads[act_idx]);
    assign out_free   = !out_valid_reg || res.ready;

    assign match = (qty_reg != '0) && (head.price == price_reg);
    assign trade = !match ? '0 : ((head.qty < qty_reg) ? head.qty : qty_reg);
    assign rem   = head.qty - trade;
    assign hit   = !found_reg && (head.id == oid_reg) && !head.detached
                   && (head.client == cli_reg);

    assign self_code  = {1'b0, cli_reg};
    assign other_code = head.detached ? DETACHED_CODE : {1'b0, head.client};
    // The live part of a rotating list spans the unwalked and kept entries.
    assign wsum = CNT_W'(u_reg + k_reg - 1'b1);

    for (genvar l = 0; l < NUM_LISTS; l++)
    begin : g_list
        epom_list #(
            .LIST_DEPTH (LIST_DEPTH),
            .PRICE_BITS (PRICE_BITS),
            .IDX_W      (IDX_W),
            .EW         (EW)
        ) u_list (
            .clk      (clk),
            .ctrl     (ctrl[l]),
            .wr_pos   (wr_pos),
            .wr_entry (wr_entry),
            .head     (heads[l])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        inst_next     = inst_reg;
        side_next     = side_reg;
        price_next    = price_reg;
        qty_next      = qty_reg;
        cli_next      = cli_reg;
        oid_next      = oid_reg;
        lsel_next     = lsel_reg;
        u_next        = u_reg;
        k_next        = k_reg;
        found_next    = found_reg;
        fin_kind_next = fin_kind_reg;
        cnt_next      = cnt_reg;

        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        out_price_next = out_price_reg;
        out_qty_next   = out_qty_reg;
        out_inst_next  = out_inst_reg;
        out_buy_next   = out_buy_reg;
        out_sell_next  = out_sell_reg;
        out_last_next  = out_last_reg;

        for (int l = 0; l < NUM_LISTS; l++)
        begin
            ctrl[l] = '0;
            ctrl[l].det_client = cli_reg;
        end
        wr_pos   = wsum[IDX_W-1:0];
        wr_entry = head;
        wr_entry.qty = rem;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    inst_next  = req.instrument;
                    side_next  = req.side;
                    price_next = req.price;
                    qty_next   = req.quantity;
                    cli_next   = req.client_id;
                    oid_next   = req.order_id;
                    k_next     = '0;
                    found_next = 1'b0;
                    lsel_next  = '0;
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            u_next     = cnt_reg[in_opp_idx];
                            state_next = ST_ADD_WALK;
                        end
                        REQ_CANCEL:
                        begin
                            u_next     = cnt_reg[0];
                            state_next = ST_CAN_WALK;
                        end
                        REQ_DETACH:
                        begin
                            state_next = ST_DETACH;
                        end
                        default:
                        begin
                            fin_kind_next = RES_NOT_FOUND;
                            state_next    = ST_FINAL;
                        end
                    endcase
                end
            end
            ST_ADD_WALK:
            begin
                if (u_reg == '0)
                begin
                    cnt_next[opp_idx] = k_reg;
                    state_next        = ST_ADD_REST;
                end
                else if (out_free)
                begin
                    ctrl[opp_idx].shift = 1'b1;
                    ctrl[opp_idx].wr_en = (rem != '0);
                    u_next   = u_reg - 1'b1;
                    k_next   = k_reg + CNT_W'(rem != '0);
                    qty_next = qty_reg - trade;
                    if (match)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = RES_FILL;
                        out_price_next = price_reg;
                        out_qty_next   = trade;
                        out_inst_next  = inst_reg;
                        out_buy_next   = side_reg ? other_code : self_code;
                        out_sell_next  = side_reg ? self_code : other_code;
                        out_last_next  = 1'b0;
                    end
                end
            end
            ST_ADD_REST:
            begin
                wr_pos   = cnt_reg[own_idx][IDX_W-1:0];
                wr_entry = '{price: price_reg, qty: qty_reg, client: cli_reg,
                             detached: 1'b0, id: oid_reg};
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_price_next = '0;
                    out_qty_next   = '0;
                    out_inst_next  = 1'b0;
                    out_buy_next   = '0;
                    out_sell_next  = '0;
                    out_last_next  = 1'b1;
                    if (qty_reg == '0)
                    begin
                        out_kind_next = RES_FILLED;
                    end
                    else if (cnt_reg[own_idx] < CNT_W'(LIST_DEPTH))
                    begin
                        ctrl[own_idx].wr_en = 1'b1;
                        cnt_next[own_idx]   = cnt_reg[own_idx] + 1'b1;
                        out_kind_next       = RES_RESTED;
                    end
                    else
                    begin
                        out_kind_next = RES_REJECTED;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CAN_WALK:
            begin
                if (u_reg == '0)
                begin
                    cnt_next[lsel_reg] = k_reg;
                    if (found_reg || (lsel_reg == 2'd3))
                    begin
                        fin_kind_next = found_reg ? RES_CANCELLED : RES_NOT_FOUND;
                        state_next    = ST_FINAL;
                    end
                    else
                    begin
                        lsel_next = lsel_reg + 1'b1;
                        u_next    = cnt_reg[lsel_reg + 1'b1];
                        k_next    = '0;
                    end
                end
                else
                begin
                    ctrl[lsel_reg].shift = 1'b1;
                    ctrl[lsel_reg].wr_en = !hit;
                    wr_entry   = head;
                    u_next     = u_reg - 1'b1;
                    k_next     = k_reg + CNT_W'(!hit);
                    found_next = found_reg || hit;
                end
            end
            ST_DETACH:
            begin
                for (int l = 0; l < NUM_LISTS; l++)
                begin
                    ctrl[l].detach = 1'b1;
                end
                fin_kind_next = RES_DETACHED;
                state_next    = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = fin_kind_reg;
                    out_price_next = '0;
                    out_qty_next   = '0;
                    out_inst_next  = 1'b0;
                    out_buy_next   = '0;
                    out_sell_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < NUM_LISTS; l++)
            begin
                cnt_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inst_reg      <= inst_next;
        side_reg      <= side_next;
        price_reg     <= price_next;
        qty_reg       <= qty_next;
        cli_reg       <= cli_next;
        oid_reg       <= oid_next;
        lsel_reg      <= lsel_next;
        u_reg         <= u_next;
        k_reg         <= k_next;
        found_reg     <= found_next;
        fin_kind_reg  <= fin_kind_next;
        out_kind_reg  <= out_kind_next;
        out_price_reg <= out_price_next;
        out_qty_reg   <= out_qty_next;
        out_inst_reg  <= out_inst_next;
        out_buy_reg   <= out_buy_next;
        out_sell_reg  <= out_sell_next;
        out_last_reg  <= out_last_next;
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.result_kind     = out_kind_reg;
    assign res.fill_price      = out_price_reg;
    assign res.fill_quantity   = out_qty_reg;
    assign res.fill_instrument = out_inst_reg;
    assign res.buy_client      = out_buy_reg;
    assign res.sell_client     = out_sell_reg;
    assign res.last_result     = out_last_reg;

    `EPOM_ASSERT(a_cnt_bound, (cnt_reg[0] <= CNT_W'(LIST_DEPTH)) && (cnt_reg[1] <= CNT_W'(LIST_DEPTH)) && (cnt_reg[2] <= CNT_W'(LIST_DEPTH)) && (cnt_reg[3] <= CNT_W'(LIST_DEPTH)), "list count beyond depth")
    `EPOM_ASSERT(a_walk_span, (state_reg == ST_ADD_WALK) |-> ({1'b0, u_reg} + {1'b0, k_reg} <= {1'b0, cnt_reg[opp_idx]}), "walk overruns the list")
    `EPOM_ASSERT(a_one_request, (req.valid && req.ready) |=> !req.ready, "request taken while busy")
    `EPOM_ASSERT(a_fill_not_last, (res.valid && (res.result_kind == RES_FILL)) |-> !res.last_result, "fill marked last")
    `EPOM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !res.valid, "result shown in reset")

endmodule
`default_nettype wire
